FILE: rtl/multi_server_queue_wait_time_macros.svh
// assertion macros for the multi-server queue block
// used by the top level only
`ifndef MULTI_SERVER_QUEUE_WAIT_TIME_MACROS_SVH
`define MULTI_SERVER_QUEUE_WAIT_TIME_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define MSQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define MSQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: rtl/msqwt_pkg.sv
// shared types and constants for the multi-server queue block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package msqwt_pkg;
   localparam int CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIXED_N  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PERIOD_N = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PSERVERS = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DUR0     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DUR1     = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DUR2     = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DUR3     = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ENDS, ST_ADJ, ST_SCAN, ST_UPDATE, ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture the input item
      logic end_step; // accumulate one period end
      logic adj_step; // move one off-duty server
      logic scan_step; // compare one server
      logic update;   // write the chosen server and form the result
      logic none;     // form a no-server result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ends_last;
      logic adj_last;
      logic scan_last;
      logic sched;
      logic empty;    // no server at all, or a zero horizon, in scheduled mode
      logic past;     // chosen server at or past the horizon
   } sts_type;
endpackage
`default_nettype wire

FILE: rtl/msqwt_ctrl.sv
// sequencing state machine for the multi-server queue block
// depends on msqwt_pkg
`timescale 1ns / 1ps
`default_nettype none
module msqwt_ctrl import msqwt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_fire,
   input  wire logic    out_free,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         busy
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (in_fire) state_in = sts.sched ? ST_ENDS : ST_SCAN;
         ST_ENDS:   if (sts.ends_last) state_in = sts.empty ? ST_DONE : ST_ADJ;
         ST_ADJ:    if (sts.adj_last) state_in = ST_SCAN;
         ST_SCAN:   if (sts.scan_last) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:   cmd.load = in_fire;
         ST_ENDS: begin
            cmd.end_step = 1'b1;
            cmd.none = sts.ends_last & sts.empty;
         end
         ST_ADJ:    cmd.adj_step = 1'b1;
         ST_SCAN:   cmd.scan_step = 1'b1;
         ST_UPDATE: begin
            cmd.update = ~(sts.sched & sts.past);
            cmd.none = sts.sched & sts.past;
         end
         ST_DONE:   ;
         default:   ;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
endmodule
`default_nettype wire

FILE: rtl/msqwt_dp.sv
// datapath: busy-until store, period ends, server scan and result register
// depends on msqwt_pkg
`timescale 1ns / 1ps
`default_nettype none
module msqwt_dp import msqwt_pkg::*; #(
   parameter int MAX_SERVERS = 16,
   parameter int MAX_PERIODS = 4,
   parameter int TIME_BITS   = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cmd_type       cmd,
   output sts_type            sts,
   input  wire logic [31:0]   arrival_time,
   input  wire logic [31:0]   service_time,
   input  wire logic          first_of_run,
   input  wire logic          csr_we,
   input  wire logic [CSR_IDX_BITS-1:0] csr_idx,
   input  wire logic [31:0]   csr_data,
   input  wire logic          out_take,
   output logic               out_valid,
   output logic [31:0]        wait_time,
   output logic               no_server,
   output logic [3:0]         server_index
);
   localparam int SB = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int NB = $clog2(MAX_SERVERS + 1);
   localparam int PB = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
   localparam int CW = NB + 1;
   localparam logic [TIME_BITS-1:0] TMAX = '1;
   typedef logic [TIME_BITS-1:0] time_type;

   // configuration
   logic        mode_ff;
   logic [4:0]  fixed_n_ff;
   logic [2:0]  period_n_ff;
   logic [19:0] pservers_ff;
   logic [31:0] dur_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0; fixed_n_ff <= 5'd1; period_n_ff <= 3'd1;
         pservers_ff <= 20'd1;
         for (int i = 0; i < 4; i++) dur_ff[i] <= '0;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_MODE:     mode_ff <= csr_data[0];
            CSR_FIXED_N:  fixed_n_ff <= csr_data[4:0];
            CSR_PERIOD_N: period_n_ff <= csr_data[2:0];
            CSR_PSERVERS: pservers_ff <= csr_data[19:0];
            CSR_DUR0:     dur_ff[0] <= csr_data;
            CSR_DUR1:     dur_ff[1] <= csr_data;
            CSR_DUR2:     dur_ff[2] <= csr_data;
            CSR_DUR3:     dur_ff[3] <= csr_data;
            default:      ;
         endcase
      end
   end

   function automatic time_type clamp32(input logic [31:0] v);
      logic [63:0] w;
      w = {32'd0, v};
      if (w > {{(64-TIME_BITS){1'b0}}, TMAX}) return TMAX;
      return w[TIME_BITS-1:0];
   endfunction

   function automatic time_type sat_add(input time_type a, input time_type b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
   endfunction

   // per-period server count, saturated to MAX_SERVERS
   function automatic logic [NB-1:0] pcount(input logic [19:0] ps, input int p);
      logic [4:0] c;
      c = ps[5*(p%4) +: 5];
      if (int'(c) > MAX_SERVERS) return NB'(MAX_SERVERS);
      return NB'(c);
   endfunction

   logic [PB:0] np;
   always_comb begin
      if (period_n_ff == 3'd0)               np = (PB+1)'(1);
      else if (int'(period_n_ff) > MAX_PERIODS) np = (PB+1)'(MAX_PERIODS);
      else                                   np = (PB+1)'(period_n_ff);
   end
   logic [NB-1:0] nfix;
   always_comb begin
      if (fixed_n_ff == 5'd0)                 nfix = NB'(1);
      else if (int'(fixed_n_ff) > MAX_SERVERS) nfix = NB'(MAX_SERVERS);
      else                                    nfix = NB'(fixed_n_ff);
   end

   // item registers
   time_type arr_ff, svc_ff;
   time_type ends_ff [MAX_PERIODS];
   time_type acc_ff;
   logic [PB:0] pi_ff;
   logic [NB-1:0] maxn_ff, n_ff;
   logic [SB:0]  si_ff;
   logic [SB-1:0] best_ff;
   time_type best_t_ff;

   // busy-until store with one valid bit per server, cleared on first_of_run
   time_type busy_mem [MAX_SERVERS];
   logic [MAX_SERVERS-1:0] vld_ff;

   logic [SB-1:0] rd_idx;
   assign rd_idx = si_ff[SB-1:0];
   time_type cur_t;
   assign cur_t = vld_ff[rd_idx] ? busy_mem[rd_idx] : '0;
   time_type horizon;
   assign horizon = ends_ff[PB'(np - 1'b1)];

   // scheduled move of one server
   time_type adj_t;
   logic     adj_do;
   always_comb begin
      logic [CW-1:0] sv;
      logic [PB:0] p, q;
      logic found;
      sv = CW'(si_ff);
      adj_do = 1'b0;
      adj_t = cur_t;
      p = (PB+1)'(MAX_PERIODS);
      q = '0;
      found = 1'b0;
      for (int k = 0; k < MAX_PERIODS; k++) begin
         if (!found && (PB+1)'(k) < np && !(ends_ff[k] <= cur_t)) begin
            p = (PB+1)'(k); found = 1'b1;
         end
      end
      if (cur_t < horizon && found && CW'(pcount(pservers_ff, int'(p))) <= sv) begin
         adj_do = 1'b1;
         adj_t = horizon;
         found = 1'b0;
         for (int k = 0; k < MAX_PERIODS; k++) begin
            q = (PB+1)'(k);
            if (!found && q > p && q < np && CW'(pcount(pservers_ff, k)) > sv) begin
               adj_t = ends_ff[(k + MAX_PERIODS - 1) % MAX_PERIODS];
               found = 1'b1;
            end
         end
      end
   end

   time_type start_t;
   assign start_t = (best_t_ff > arr_ff) ? best_t_ff : arr_ff;
   time_type wait_t;
   assign wait_t = start_t - arr_ff;

   logic [NB-1:0] pc_cur;
   assign pc_cur = pcount(pservers_ff, int'(pi_ff[PB-1:0]));

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (cmd.load && first_of_run) vld_ff <= '0;
      else if (cmd.adj_step && adj_do) vld_ff[rd_idx] <= 1'b1;
      else if (cmd.update) vld_ff[best_ff] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.adj_step && adj_do) busy_mem[rd_idx] <= adj_t;
      else if (cmd.update) busy_mem[best_ff] <= sat_add(start_t, svc_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         arr_ff <= clamp32(arrival_time);
         svc_ff <= clamp32(service_time);
         acc_ff <= '0; pi_ff <= '0; maxn_ff <= '0;
         si_ff <= '0; best_ff <= '0; best_t_ff <= TMAX;
         n_ff <= nfix;
      end
      if (cmd.end_step) begin
         acc_ff <= sat_add(acc_ff, clamp32(dur_ff[pi_ff[PB-1:0]]));
         ends_ff[pi_ff[PB-1:0]] <= sat_add(acc_ff, clamp32(dur_ff[pi_ff[PB-1:0]]));
         pi_ff <= pi_ff + 1'b1;
         if (pc_cur > maxn_ff) maxn_ff <= pc_cur;
         if (sts.ends_last) n_ff <= (pc_cur > maxn_ff) ? pc_cur : maxn_ff;
      end
      if (cmd.adj_step) si_ff <= sts.adj_last ? '0 : si_ff + 1'b1;
      if (cmd.scan_step) begin
         si_ff <= si_ff + 1'b1;
         if (si_ff == '0 || cur_t < best_t_ff) begin
            best_ff <= rd_idx; best_t_ff <= cur_t;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else if (cmd.update || cmd.none) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (cmd.none) begin
         wait_time <= '0; no_server <= 1'b1; server_index <= '0;
      end else if (cmd.update) begin
         wait_time <= (TIME_BITS > 32 && |(64'(wait_t) >> 32)) ? 32'hFFFF_FFFF
                      : 32'(wait_t);
         no_server <= 1'b0;
         server_index <= 4'(best_ff);
      end
   end

   logic [NB-1:0] maxn_now;
   assign maxn_now = (pc_cur > maxn_ff) ? pc_cur : maxn_ff;
   always_comb begin
      sts.sched = mode_ff;
      sts.ends_last = (pi_ff + 1'b1 == np);
      sts.empty = (maxn_now == '0) || (sat_add(acc_ff, clamp32(dur_ff[pi_ff[PB-1:0]])) == '0);
      sts.adj_last = (CW'(si_ff) + 1'b1 >= CW'(n_ff));
      sts.scan_last = (CW'(si_ff) + 1'b1 >= CW'(n_ff));
      sts.past = (best_t_ff >= horizon);
   end
endmodule
`default_nettype wire

FILE: rtl/multi_server_queue_wait_time.sv
// top level of the multi-server queue wait-time block
// depends on msqwt_pkg, msqwt_ctrl, msqwt_dp and the macros header
//
// channel | direction | payload
// req     | in        | tdata {first_of_run, service_time, arrival_time}
// rsp     | out       | tdata {server_index, no_server, wait_time}
// csr     | in        | index, data
//
// fixed mode: N scan steps after the req transfer, then an update step forms the result
// scheduled: P period-end steps, N adjust and N scan steps, then an update step; with no
// server or a zero horizon only the P steps; no new req is taken until the result is taken
// reset is synchronous and clears the store by valid bits.
// the result waits in an output register; a stalled rsp holds the next item.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_server_queue_wait_time_macros.svh"
module multi_server_queue_wait_time import msqwt_pkg::*; #(
   parameter int MAX_SERVERS = 16,
   parameter int MAX_PERIODS = 4,
   parameter int TIME_BITS   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // arrival_time, service_time, first_of_run
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // wait_time, no_server, server_index
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   cmd_type cmd;
   sts_type sts;
   logic busy, in_fire;
   logic [31:0] wt;
   logic ns;
   logic [3:0] si;

   assign req_tready = ~busy;
   assign in_fire = req_tvalid & req_tready;
   assign csr_ready = 1'b1;

   msqwt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_fire(in_fire),
      .out_free(~rsp_tvalid | rsp_tready), .sts(sts), .cmd(cmd), .busy(busy)
   );

   msqwt_dp #(.MAX_SERVERS(MAX_SERVERS), .MAX_PERIODS(MAX_PERIODS),
              .TIME_BITS(TIME_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .arrival_time(req_tdata[31:0]), .service_time(req_tdata[63:32]),
      .first_of_run(req_tdata[64]),
      .csr_we(csr_valid & csr_ready), .csr_idx(csr_index), .csr_data(csr_data),
      .out_take(rsp_tready), .out_valid(rsp_tvalid),
      .wait_time(wt), .no_server(ns), .server_index(si)
   );

   assign rsp_tdata = {3'd0, si, ns, wt};

   `MSQ_ASSERT_IMP(a_busy_on_load, clock, reset, cmd.load, ~busy, "load while busy")
   `MSQ_ASSERT_IMP(a_one_result, clock, reset, cmd.update, ~cmd.none, "two result kinds")
   `MSQ_ASSERT_NXT(a_load_busy, clock, reset, in_fire, busy, "no busy after accept")
endmodule
`default_nettype wire

FILE: verif/tb_multi_server_queue_wait_time.sv
// testbench for the multi-server queue wait-time block: random customers under many configurations
// depends on msqwt_pkg and multi_server_queue_wait_time; predicts each result in a scoreboard class
`timescale 1ns / 1ps
`default_nettype none

class queue_scoreboard;
   typedef struct {
      logic [31:0] wait_time;
      logic        no_server;
      logic [3:0]  server_index;
   } outcome_type;

   logic [31:0] busy_until [16];
   logic        sched_mode;
   logic [4:0]  fixed_n;
   logic [2:0]  period_n;
   logic [19:0] period_srv;
   logic [31:0] period_dur [4];
   outcome_type pending [$];
   int          errors;
   int          checked;
   int          none_count;

   function new();
      foreach (busy_until[i]) busy_until[i] = '0;
      sched_mode = 1'b0;
      fixed_n    = 5'd1;
      period_n   = 3'd1;
      period_srv = 20'd1;
      foreach (period_dur[i]) period_dur[i] = '0;
      errors = 0;
      checked = 0;
      none_count = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
         msqwt_pkg::CSR_MODE:     sched_mode = value[0];
         msqwt_pkg::CSR_FIXED_N:  fixed_n = value[4:0];
         msqwt_pkg::CSR_PERIOD_N: period_n = value[2:0];
         msqwt_pkg::CSR_PSERVERS: period_srv = value[19:0];
         default:                 period_dur[idx - msqwt_pkg::CSR_DUR0] = value;
      endcase
   endfunction

   function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function int servers_in(int p);
      int c;
      c = (period_srv >> (5 * p)) & 31;
      return (c > 16) ? 16 : c;
   endfunction

   function int earliest(int n);
      int best;
      best = 0;
      for (int i = 1; i < n; i++)
         if (busy_until[i] < busy_until[best]) best = i;
      return best;
   endfunction

   function void note_input(logic [31:0] arrival, logic [31:0] service, logic first);
      outcome_type o;
      logic [31:0] ends [4];
      logic [31:0] horizon, acc, t, start;
      int n, np, maxn, s, p, q;
      o.wait_time = '0;
      o.no_server = 1'b1;
      o.server_index = '0;
      if (first) foreach (busy_until[i]) busy_until[i] = '0;
      if (!sched_mode) begin
         n = (fixed_n == 0) ? 1 : ((fixed_n > 16) ? 16 : fixed_n);
         s = earliest(n);
      end else begin
         np = (period_n == 0) ? 1 : ((period_n > 4) ? 4 : period_n);
         maxn = 0;
         acc = '0;
         for (p = 0; p < np; p++) begin
            acc = add_sat(acc, period_dur[p]);
            ends[p] = acc;
            if (servers_in(p) > maxn) maxn = servers_in(p);
         end
         horizon = ends[np-1];
         if (maxn == 0 || horizon == 0) s = -1;
         else begin
            // off-duty servers jump forward to their next on-duty period
            for (int k = 0; k < maxn; k++) begin
               t = busy_until[k];
               if (t >= horizon) continue;
               for (p = 0; p < np && ends[p] <= t; p++) ;
               if (p >= np || servers_in(p) > k) continue;
               for (q = p + 1; q < np && servers_in(q) <= k; q++) ;
               busy_until[k] = (q < np) ? ends[q-1] : horizon;
            end
            s = earliest(maxn);
            if (busy_until[s] >= horizon) s = -1;
         end
      end
      if (s >= 0) begin
         start = (busy_until[s] > arrival) ? busy_until[s] : arrival;
         o.wait_time = start - arrival;
         o.no_server = 1'b0;
         o.server_index = s[3:0];
         busy_until[s] = add_sat(start, service);
      end
      pending.push_back(o);
   endfunction

   function void check_result(logic [39:0] data);
      outcome_type o;
      checked++;
      if (data[32]) none_count++;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result %h", $time, data);
         errors++;
         return;
      end
      o = pending.pop_front();
      if (data[31:0] !== o.wait_time) begin
         $display("%0t: wait_time expected %h actual %h", $time, o.wait_time, data[31:0]);
         errors++;
      end
      if (data[32] !== o.no_server) begin
         $display("%0t: no_server expected %b actual %b", $time, o.no_server, data[32]);
         errors++;
      end
      if (data[36:33] !== o.server_index) begin
         $display("%0t: server_index expected %0d actual %0d", $time, o.server_index,
                  data[36:33]);
         errors++;
      end
   endfunction
endclass

module tb_multi_server_queue_wait_time;
   import msqwt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;  // arrival_time, service_time, first_of_run
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;       // wait_time, no_server, server_index
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   queue_scoreboard sb = new();
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int hold_requests  = 0;
   int items_sent     = 0;
   logic [31:0] next_arrival = '0;

   multi_server_queue_wait_time u_top (.*);

   always #1 clock = ~clock;

   // receiver backpressure, with long hold-offs requested by the main process
   always @(negedge clock) begin
      static int hold_left = 0;
      static int hold_seen = 0;
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);

   task automatic write_csr(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_customer(logic [31:0] arrival, logic [31:0] service, logic first);
      if (req_tvalid && $urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {7'd0, first, service, arrival};
      do @(posedge clock); while (!req_tready);
      sb.note_input(arrival, service, first);
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic random_customer();
      logic [31:0] service;
      int r;
      r = $urandom_range(99);
      if (r < 5) next_arrival = $urandom;
      else if (r < 9) next_arrival = 32'hFFFF_FFFF;
      else if (r < 85) next_arrival = sb.add_sat(next_arrival, $urandom_range(0, 1500));
      r = $urandom_range(99);
      service = (r < 5) ? 32'hFFFF_FFFF : (r < 10) ? 32'd0 : (r < 14) ? $urandom
              : $urandom_range(0, 3000);
      send_customer(next_arrival, service, $urandom_range(99) < 8);
   endtask

   task automatic directed_customers();
      send_customer(32'd0, 32'd0, 1'b1);
      send_customer(32'd0, 32'd100, 1'b0);
      send_customer(32'd0, 32'd100, 1'b0);
      send_customer(32'd50, 32'hFFFF_FFFF, 1'b0);
      send_customer(32'd60, 32'd1, 1'b0);
      send_customer(32'h8000_0000, 32'h8000_0000, 1'b0);
      send_customer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_customer(32'hFFFF_FFFF, 32'd0, 1'b1);
      send_customer(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
      send_customer(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
      next_arrival = '0;
   endtask

   // mode, fixed count, period count, period server counts, four durations
   logic [31:0] setting [12][8] = '{
      '{0, 1, 1, 1, 0, 0, 0, 0},
      '{0, 16, 1, 1, 0, 0, 0, 0},
      '{0, 0, 1, 1, 0, 0, 0, 0},
      '{0, 31, 1, 1, 0, 0, 0, 0},
      '{1, 1, 4, (3 << 15) | (1 << 10) | (4 << 5) | 2, 3000, 3000, 3000, 3000},
      '{1, 1, 2, 16, 20000, 10000, 0, 0},
      '{1, 1, 1, 0, 5000, 0, 0, 0},
      '{1, 1, 7, (17 << 15) | (5 << 10) | 31, 32'hFFFF_FFFF, 0, 5000, 32'hFFFF_FFFF},
      '{1, 1, 0, 4, 0, 100, 100, 100},
      '{1, 1, 3, (8 << 10) | (3 << 5), 1000, 4000, 8000, 0},
      '{1, 5, 5, 20'hFFFFF, 2000, 2000, 2000, 2000},
      '{1, 5, 4, 0, 0, 0, 0, 0}
   };

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 11) begin
            setting[ph][3] = $urandom_range(0, 20'hFFFFF);
            for (int d = 4; d < 8; d++) setting[ph][d] = $urandom_range(0, 6000);
         end
         for (int r = 0; r < 8; r++) write_csr(r[2:0], setting[ph][r]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 55; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 55; end
            default: begin send_idle_pct = 8; stall_pct = 8; end
         endcase
         if (ph == 0 || ph == 4) directed_customers();
         if (ph == 5) hold_requests++;  // block fills up behind a stalled receiver
         for (int i = 0; i < 165; i++) begin
            // one pause with nothing in flight
            if (ph == 6 && i == 80) drain();
            random_customer();
         end
         drain();
      end
      $display("covered %0d customers over 12 register settings, %0d results checked",
               items_sent, sb.checked);
      $display("fixed and scheduled modes, saturation, off-duty moves; %0d no-server results",
               sb.none_count);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end
endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/msqwt_pkg.sv
rtl/msqwt_ctrl.sv
rtl/msqwt_dp.sv
rtl/multi_server_queue_wait_time.sv
verif/tb_multi_server_queue_wait_time.sv
